// ===== rtl/gn2_pkg.sv =====
`timescale 1ns / 1ps

package gn2_pkg;

  // Permutation table geometry
  localparam int TABLE_SIZE = 256;
  localparam int TBL_AW     = $clog2(TABLE_SIZE);
  localparam int PERM_W     = 8;

  // Coordinate formats
  localparam int COORD_W       = 24;
  localparam int CELL_W        = 8;
  localparam int FRAC_W        = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int FRAC_BITS_MAX = 24;
  // Sign-extended coordinate with FRAC_W zero bits appended below it
  localparam int SPLIT_W       = FRAC_BITS_MAX + CELL_W + FRAC_W;
  localparam int SEXT_W        = SPLIT_W - FRAC_W - COORD_W;

  // Datapath widths
  localparam int DOT_W   = 19;   // corner dot product, Q16 signed
  localparam int FADE_W  = 17;   // fade weight, Q16 unsigned, up to 1.0
  localparam int NOISE_W = 16;

  // Pipeline depth, input register through output register
  localparam int NUM_STAGES = 10;

  // Mode codes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  // Fade polynomial constant term, 10 in Q16
  localparam logic [19:0] FADE_TEN_Q16 = 20'd655360;

  // sqrt(2) in Q16
  localparam logic signed [17:0] SQRT2_Q16 = 18'sd92682;

  // Item as seen by the hash lookup
  typedef struct packed {
    logic              valid;
    logic              is_write;
    logic [TBL_AW-1:0] index;
    logic [PERM_W-1:0] value;
    logic [CELL_W-1:0] xi;
    logic [CELL_W-1:0] yi;
  } hash_req_t;

  // Gradient selects of the four corners
  typedef struct packed {
    logic [1:0] bl;
    logic [1:0] tl;
    logic [1:0] br;
    logic [1:0] tr;
  } hash_out_t;

endpackage

// ===== rtl/gn2_hash.sv =====
`timescale 1ns / 1ps

module gn2_hash (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en_l1,
  input  logic                  en_l2,
  input  gn2_pkg::hash_req_t    req,
  output gn2_pkg::hash_out_t    hash
);

  // Level-one copy, and two level-two copies so four corners read per cycle while en_l2 is high
  logic [gn2_pkg::PERM_W-1:0] perm_l1  [gn2_pkg::TABLE_SIZE];
  logic [gn2_pkg::PERM_W-1:0] perm_l2a [gn2_pkg::TABLE_SIZE];
  logic [gn2_pkg::PERM_W-1:0] perm_l2b [gn2_pkg::TABLE_SIZE];

  gn2_pkg::hash_req_t         req2;
  logic                       wr2;
  logic [gn2_pkg::PERM_W-1:0] a_q;
  logic [gn2_pkg::PERM_W-1:0] b_q;

  logic [gn2_pkg::TBL_AW-1:0] addr_a0;
  logic [gn2_pkg::TBL_AW-1:0] addr_a1;
  logic [gn2_pkg::TBL_AW-1:0] addr_b0;
  logic [gn2_pkg::TBL_AW-1:0] addr_b1;

  // Level one: perm[xi] and perm[xi+1]; a write lands here in item order
  always_ff @(posedge clk) begin
    if (en_l1) begin
      a_q  <= perm_l1[req.xi];
      b_q  <= perm_l1[req.xi + gn2_pkg::TBL_AW'(1)];
      req2 <= req;
      if (req.valid && req.is_write) begin
        perm_l1[req.index] <= req.value;
      end
    end
  end

  // Write strobe for level two
  always_ff @(posedge clk) begin
    if (rst) begin
      wr2 <= 1'b0;
    end else if (en_l1) begin
      wr2 <= req.valid && req.is_write;
    end
  end

  // Level-two addresses wrap mod table size
  assign addr_a0 = a_q + req2.yi;
  assign addr_a1 = a_q + req2.yi + gn2_pkg::TBL_AW'(1);
  assign addr_b0 = b_q + req2.yi;
  assign addr_b1 = b_q + req2.yi + gn2_pkg::TBL_AW'(1);

  // Level two: only the gradient select bits are kept
  always_ff @(posedge clk) begin
    if (en_l2) begin
      hash.bl <= perm_l2a[addr_a0][1:0];
      hash.tl <= perm_l2a[addr_a1][1:0];
      hash.br <= perm_l2b[addr_b0][1:0];
      hash.tr <= perm_l2b[addr_b1][1:0];
      if (wr2) begin
        perm_l2a[req2.index] <= req2.value;
        perm_l2b[req2.index] <= req2.value;
      end
    end
  end

endmodule

// ===== rtl/gn2_fade.sv =====
`timescale 1ns / 1ps

module gn2_fade (
  input  logic                         clk,
  input  logic                         en_sq,
  input  logic                         en_cube,
  input  logic                         en_mul,
  input  logic [gn2_pkg::FRAC_W-1:0]   t,
  output logic [gn2_pkg::FADE_W-1:0]   fade
);

  logic [31:0] tt;
  logic [15:0] t_d;
  logic [31:0] t3;
  logic [19:0] poly;
  logic [51:0] prod;

  logic [34:0] six_tt;
  logic [19:0] fifteen_t;

  // t^2
  always_ff @(posedge clk) begin
    if (en_sq) begin
      tt  <= t * t;
      t_d <= t;
    end
  end

  // 6t^2 - 15t + 10, kept at Q16 after dropping the exact low bits
  assign six_tt    = ({3'b0, tt} << 2) + ({3'b0, tt} << 1);
  assign fifteen_t = ({4'b0, t_d} << 4) - {4'b0, t_d};

  // t^3 and the polynomial
  always_ff @(posedge clk) begin
    if (en_cube) begin
      t3   <= tt[31:16] * t_d;
      poly <= 20'(six_tt[34:16]) + gn2_pkg::FADE_TEN_Q16 - fifteen_t;
    end
  end

  // t^3 * poly
  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod <= t3 * poly;
    end
  end

  assign fade = prod[32 +: gn2_pkg::FADE_W];

endmodule

// ===== rtl/gn2_lerp.sv =====
`timescale 1ns / 1ps

module gn2_lerp (
  input  logic                               clk,
  input  logic                               en_mul,
  input  logic                               en_sum,
  input  logic [gn2_pkg::FADE_W-1:0]         w,
  input  logic signed [gn2_pkg::DOT_W-1:0]   a,
  input  logic signed [gn2_pkg::DOT_W-1:0]   b,
  output logic signed [gn2_pkg::DOT_W-1:0]   y
);

  logic signed [gn2_pkg::DOT_W:0]     diff;
  logic signed [37:0]                 prod;
  logic signed [gn2_pkg::DOT_W-1:0]   a_d;
  logic signed [21:0]                 sum;

  assign diff = {b[gn2_pkg::DOT_W-1], b} - {a[gn2_pkg::DOT_W-1], a};

  // w * (b - a)
  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod <= $signed({1'b0, w}) * diff;
      a_d  <= a;
    end
  end

  // a + floor(product / 2^16); the result lies between a and b
  assign sum = {{(22 - gn2_pkg::DOT_W){a_d[gn2_pkg::DOT_W-1]}}, a_d} + prod[37:16];

  always_ff @(posedge clk) begin
    if (en_sum) begin
      y <= sum[gn2_pkg::DOT_W-1:0];
    end
  end

endmodule

// ===== rtl/gradient_noise_2d.sv =====
`timescale 1ns / 1ps

// Channel  Handshake             Fields
// in       in_valid / in_ready   mode, table_index, table_value, x_coord, y_coord
// out      out_valid / out_ready noise_value
//
// One transaction per cycle in both directions while out_ready is high; an evaluate
// transaction gives a result at the output register, a table write gives none.
// The ten register stages are the input register, two table-read stages, the
// dot products, two multiply/add pairs for the blends, the sqrt2 scale and
// the output register. Reset clears the stage valid bits and the hash write strobe
// only; the table holds nothing until loaded.
// With out_ready low the output stage holds; empty stages behind it close up and
// in_ready drops only when every stage is full.

module gradient_noise_2d #(
  parameter int FRAC_BITS = gn2_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  mode,
  input  logic [gn2_pkg::TBL_AW-1:0]            table_index,
  input  logic [gn2_pkg::PERM_W-1:0]            table_value,
  input  logic signed [gn2_pkg::COORD_W-1:0]    x_coord,
  input  logic signed [gn2_pkg::COORD_W-1:0]    y_coord,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [gn2_pkg::NOISE_W-1:0]    noise_value
);

  localparam int NS = gn2_pkg::NUM_STAGES;
  localparam int DW = gn2_pkg::DOT_W;
  localparam int FW = gn2_pkg::FRAC_W;

  localparam logic signed [37:0] ROUND_HALF = 38'sd65536;
  localparam logic signed [20:0] Q_MAX      = 21'sd32767;
  localparam logic signed [20:0] Q_MIN      = -21'sd32768;

  logic [NS:1] valid;
  logic [NS:1] en;

  // Stage 1
  logic                         mode1;
  logic [gn2_pkg::TBL_AW-1:0]   idx1;
  logic [gn2_pkg::PERM_W-1:0]   val1;
  logic [gn2_pkg::CELL_W-1:0]   xi1;
  logic [gn2_pkg::CELL_W-1:0]   yi1;
  logic [FW-1:0]                xf1;
  logic [FW-1:0]                yf1;
  // Stages 2, 3
  logic                         eval2;
  logic                         eval3;
  logic [FW-1:0]                xf2;
  logic [FW-1:0]                yf2;
  logic [FW-1:0]                xf3;
  logic [FW-1:0]                yf3;
  // Stage 4
  logic signed [DW-1:0]         dot_bl;
  logic signed [DW-1:0]         dot_tl;
  logic signed [DW-1:0]         dot_br;
  logic signed [DW-1:0]         dot_tr;
  logic [gn2_pkg::FADE_W-1:0]   fade_u;
  logic [gn2_pkg::FADE_W-1:0]   fade_v;
  // Stages 5..10
  logic [gn2_pkg::FADE_W-1:0]   u5;
  logic [gn2_pkg::FADE_W-1:0]   u6;
  logic signed [DW-1:0]         left6;
  logic signed [DW-1:0]         right6;
  logic signed [DW-1:0]         n8;
  logic signed [36:0]           scaled;

  logic [gn2_pkg::SPLIT_W-1:0]  wide_x;
  logic [gn2_pkg::SPLIT_W-1:0]  wide_y;
  gn2_pkg::hash_req_t           req1;
  gn2_pkg::hash_out_t           hash3;
  logic signed [16:0]           dx0;
  logic signed [16:0]           dx1;
  logic signed [16:0]           dy0;
  logic signed [16:0]           dy1;
  logic signed [37:0]           rnd;
  logic signed [20:0]           q;

  function automatic logic signed [DW-1:0] grad_dot(
    input logic [1:0]         h,
    input logic signed [16:0] dx,
    input logic signed [16:0] dy
  );
    logic signed [DW-1:0] gx;
    logic signed [DW-1:0] gy;
    gx = h[1] ? -DW'(dx) : DW'(dx);
    gy = h[0] ? -DW'(dy) : DW'(dy);
    return gx + gy;
  endfunction

  // Stage load enables: a stage loads when empty or when the next one loads
  always_comb begin
    en[NS] = !valid[NS] || out_ready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = valid[NS];

  // Valid bits; table writes leave the pipe after the table stages
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[1]) begin
        valid[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          valid[k] <= (k == 4) ? (valid[3] && eval3) : valid[k-1];
        end
      end
    end
  end

  // Floor and fraction: the fraction aligns to Q0.16 at a fixed place
  assign wide_x = {{gn2_pkg::SEXT_W{x_coord[gn2_pkg::COORD_W-1]}}, x_coord, {FW{1'b0}}};
  assign wide_y = {{gn2_pkg::SEXT_W{y_coord[gn2_pkg::COORD_W-1]}}, y_coord, {FW{1'b0}}};

  // Stage 1: input register
  always_ff @(posedge clk) begin
    if (en[1]) begin
      mode1 <= mode;
      idx1  <= table_index;
      val1  <= table_value;
      xi1   <= wide_x[FRAC_BITS + FW +: gn2_pkg::CELL_W];
      yi1   <= wide_y[FRAC_BITS + FW +: gn2_pkg::CELL_W];
      xf1   <= wide_x[FRAC_BITS +: FW];
      yf1   <= wide_y[FRAC_BITS +: FW];
    end
  end

  assign req1 = '{
    valid:    valid[1],
    is_write: (mode1 == gn2_pkg::MODE_WRITE),
    index:    idx1,
    value:    val1,
    xi:       xi1,
    yi:       yi1
  };

  // Corner hashes, ready in stage 3
  gn2_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .en_l1 (en[2]),
    .en_l2 (en[3]),
    .req   (req1),
    .hash  (hash3)
  );

  // Fractions travel alongside the lookup
  always_ff @(posedge clk) begin
    if (en[2]) begin
      eval2 <= (mode1 == gn2_pkg::MODE_EVAL);
      xf2   <= xf1;
      yf2   <= yf1;
    end
    if (en[3]) begin
      eval3 <= eval2;
      xf3   <= xf2;
      yf3   <= yf2;
    end
  end

  // Fade weights, ready in stage 4
  gn2_fade u_fade_x (
    .clk     (clk),
    .en_sq   (en[2]),
    .en_cube (en[3]),
    .en_mul  (en[4]),
    .t       (xf1),
    .fade    (fade_u)
  );

  gn2_fade u_fade_y (
    .clk     (clk),
    .en_sq   (en[2]),
    .en_cube (en[3]),
    .en_mul  (en[4]),
    .t       (yf1),
    .fade    (fade_v)
  );

  // Offsets to the near and far corners; frac - 1.0 is the fraction with a sign bit
  assign dx0 = $signed({1'b0, xf3});
  assign dx1 = $signed({1'b1, xf3});
  assign dy0 = $signed({1'b0, yf3});
  assign dy1 = $signed({1'b1, yf3});

  // Stage 4: dot products
  always_ff @(posedge clk) begin
    if (en[4]) begin
      dot_bl <= grad_dot(hash3.bl, dx0, dy0);
      dot_tl <= grad_dot(hash3.tl, dx0, dy1);
      dot_br <= grad_dot(hash3.br, dx1, dy0);
      dot_tr <= grad_dot(hash3.tr, dx1, dy1);
    end
  end

  // x weight waits for the vertical blends
  always_ff @(posedge clk) begin
    if (en[5]) begin
      u5 <= fade_u;
    end
    if (en[6]) begin
      u6 <= u5;
    end
  end

  // Vertical blends, stages 5 and 6
  gn2_lerp u_lerp_left (
    .clk    (clk),
    .en_mul (en[5]),
    .en_sum (en[6]),
    .w      (fade_v),
    .a      (dot_bl),
    .b      (dot_tl),
    .y      (left6)
  );

  gn2_lerp u_lerp_right (
    .clk    (clk),
    .en_mul (en[5]),
    .en_sum (en[6]),
    .w      (fade_v),
    .a      (dot_br),
    .b      (dot_tr),
    .y      (right6)
  );

  // Horizontal blend, stages 7 and 8
  gn2_lerp u_lerp_mid (
    .clk    (clk),
    .en_mul (en[7]),
    .en_sum (en[8]),
    .w      (u6),
    .a      (left6),
    .b      (right6),
    .y      (n8)
  );

  // Stage 9: scale by sqrt2
  always_ff @(posedge clk) begin
    if (en[9]) begin
      scaled <= n8 * gn2_pkg::SQRT2_Q16;
    end
  end

  // Round to Q1.15 and saturate
  assign rnd = {scaled[36], scaled} + ROUND_HALF;
  assign q   = rnd[37:17];

  // Stage 10: output register
  always_ff @(posedge clk) begin
    if (en[10]) begin
      if (q > Q_MAX) begin
        noise_value <= Q_MAX[gn2_pkg::NOISE_W-1:0];
      end else if (q < Q_MIN) begin
        noise_value <= Q_MIN[gn2_pkg::NOISE_W-1:0];
      end else begin
        noise_value <= q[gn2_pkg::NOISE_W-1:0];
      end
    end
  end

`ifndef SYNTH
  // Input back-pressure only when no stage has room
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> &valid)
    else $error("in_ready low with an empty pipeline stage");

  // Room at the output always reaches the input
  a_enable_chain: assert property (@(posedge clk) disable iff (rst)
    en[NS] |-> in_ready)
    else $error("output stage advances while input is blocked");

  // A stalled dot-product stage keeps its item
  a_stage4_hold: assert property (@(posedge clk) disable iff (rst)
    valid[4] && !en[4] |=> valid[4] && $stable(dot_bl) && $stable(dot_tr))
    else $error("stalled stage 4 lost or changed its transaction");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid raised right after reset");
`endif

endmodule
